// File: hdl/cfr_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the checksummed frame receiver modules
package cfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned SUM_W   = 16;

  localparam logic [BYTE_W-1:0]  START_MARKER_RESET = 8'd126;
  localparam logic [COUNT_W-1:0] HDR_BYTES          = 9'd5;

  // header positions within a frame, start byte at position zero
  localparam logic [COUNT_W-1:0] CNT_LEN   = 9'd1;
  localparam logic [COUNT_W-1:0] CNT_TYPE  = 9'd2;
  localparam logic [COUNT_W-1:0] CNT_CK_LO = 9'd3;
  localparam logic [COUNT_W-1:0] CNT_CK_HI = 9'd4;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } cfr_op_t;

  typedef enum logic [2:0] {
    EV_TAKEN   = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BAD     = 3'd2,
    EV_BUSY    = 3'd3,
    EV_READ    = 3'd4,
    EV_NOFRAME = 3'd5
  } cfr_event_t;

  typedef struct packed {
    cfr_event_t        event_res;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] frame_size;
    logic [BYTE_W-1:0] read_data;
  } cfr_item_t;

endpackage

// File: hdl/cfr_outbuf.sv
`timescale 1ns / 1ps
// two-entry result buffer between the receiver core and the output stream
module cfr_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfr_pkg::cfr_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output cfr_pkg::cfr_item_t out_item
);
  import cfr_pkg::*;

  cfr_item_t   entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

// File: hdl/cfr_core.sv
`timescale 1ns / 1ps
// frame state, payload memory and result stage of the receiver
module cfr_core #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [cfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [cfr_pkg::BYTE_W-1:0] read_index,
  input  logic                      cfg_valid,
  input  logic [cfr_pkg::BYTE_W-1:0] cfg_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output cfr_pkg::cfr_item_t        res_item
);
  import cfr_pkg::*;

  localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(PAYLOAD_DEPTH);

  logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];

  logic [BYTE_W-1:0]  start_marker;
  logic               hunting;
  logic               hunting_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [BYTE_W-1:0]  payload_len;
  logic [BYTE_W-1:0]  payload_len_next;
  logic [BYTE_W-1:0]  type_code;
  logic [BYTE_W-1:0]  type_code_next;
  logic [BYTE_W-1:0]  ck_lo;
  logic [BYTE_W-1:0]  ck_lo_next;
  logic [BYTE_W-1:0]  ck_hi;
  logic [BYTE_W-1:0]  ck_hi_next;
  logic [SUM_W-1:0]   running_sum;
  logic [SUM_W-1:0]   running_sum_next;
  logic               frame_ready;
  logic               frame_ready_next;

  logic               r_valid;
  logic               r_valid_next;
  cfr_event_t         r_event;
  cfr_event_t         r_event_next;
  logic [BYTE_W-1:0]  r_type;
  logic [BYTE_W-1:0]  r_type_next;
  logic [BYTE_W-1:0]  r_size;
  logic [BYTE_W-1:0]  r_size_next;
  logic               r_use_mem;
  logic               r_use_mem_next;
  logic [BYTE_W-1:0]  rdata;

  logic               accept;
  logic               r_take;
  logic               mem_we;
  logic               mem_re;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] frame_end;
  logic [COUNT_W-1:0] payload_pos;
  logic [SUM_W-1:0]   ck_full;

  assign r_take   = r_valid && res_ready;
  assign in_ready = !r_valid || res_ready;
  assign accept   = in_valid && in_ready;

  assign count_inc   = byte_count + 9'd1;
  assign frame_end   = {1'b0, payload_len} + HDR_BYTES;
  assign payload_pos = byte_count - HDR_BYTES;

  always_comb begin
    hunting_next     = hunting;
    byte_count_next  = byte_count;
    payload_len_next = payload_len;
    type_code_next   = type_code;
    ck_lo_next       = ck_lo;
    ck_hi_next       = ck_hi;
    running_sum_next = running_sum;
    frame_ready_next = frame_ready;
    r_valid_next     = r_valid && !r_take;
    r_event_next     = r_event;
    r_type_next      = r_type;
    r_size_next      = r_size;
    r_use_mem_next   = r_use_mem;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    ck_full          = {ck_hi, ck_lo};
    if (accept) begin
      r_valid_next   = 1'b0;
      r_event_next   = EV_TAKEN;
      r_type_next    = '0;
      r_size_next    = '0;
      r_use_mem_next = 1'b0;
      unique case (op)
        OP_BYTE: begin
          if (frame_ready) begin
            r_valid_next = 1'b1;
            r_event_next = EV_BUSY;
            r_type_next  = type_code;
            r_size_next  = payload_len;
          end else if (hunting) begin
            if (rx_byte == start_marker) begin
              hunting_next     = 1'b0;
              byte_count_next  = 9'd1;
              running_sum_next = '0;
              r_valid_next     = 1'b1;
            end
          end else begin
            unique case (byte_count)
              CNT_LEN:   payload_len_next = rx_byte;
              CNT_TYPE:  type_code_next   = rx_byte;
              CNT_CK_LO: ck_lo_next       = rx_byte;
              CNT_CK_HI: ck_hi_next       = rx_byte;
              default: begin
                mem_we           = (payload_pos < DEPTH_CNT);
                running_sum_next = running_sum + {8'd0, rx_byte};
              end
            endcase
            ck_full         = {ck_hi_next, ck_lo};
            byte_count_next = count_inc;
            r_valid_next    = 1'b1;
            if (count_inc >= 9'd3 && count_inc >= frame_end) begin
              r_type_next = type_code_next;
              r_size_next = payload_len_next;
              if (running_sum_next == ck_full) begin
                frame_ready_next = 1'b1;
                r_event_next     = EV_GOOD;
              end else begin
                hunting_next    = 1'b1;
                byte_count_next = '0;
                r_event_next    = EV_BAD;
              end
            end
          end
        end
        OP_READ: begin
          r_valid_next = 1'b1;
          if (frame_ready) begin
            mem_re         = 1'b1;
            r_event_next   = EV_READ;
            r_type_next    = type_code;
            r_size_next    = payload_len;
            r_use_mem_next = (read_index < payload_len) &&
                             ({1'b0, read_index} < DEPTH_CNT);
          end else begin
            r_event_next = EV_NOFRAME;
          end
        end
        OP_RELEASE: begin
          if (frame_ready) begin
            frame_ready_next = 1'b0;
            hunting_next     = 1'b1;
            byte_count_next  = '0;
          end else begin
            r_valid_next = 1'b1;
            r_event_next = EV_NOFRAME;
          end
        end
        default: begin
          r_valid_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      hunting      <= 1'b1;
      byte_count   <= '0;
      payload_len  <= '0;
      type_code    <= '0;
      ck_lo        <= '0;
      ck_hi        <= '0;
      running_sum  <= '0;
      frame_ready  <= 1'b0;
      r_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        start_marker <= cfg_data;
      end
      hunting     <= hunting_next;
      byte_count  <= byte_count_next;
      payload_len <= payload_len_next;
      type_code   <= type_code_next;
      ck_lo       <= ck_lo_next;
      ck_hi       <= ck_hi_next;
      running_sum <= running_sum_next;
      frame_ready <= frame_ready_next;
      r_valid     <= r_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    r_event   <= r_event_next;
    r_type    <= r_type_next;
    r_size    <= r_size_next;
    r_use_mem <= r_use_mem_next;
  end

  // payload memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[payload_pos[ADDR_W-1:0]] <= rx_byte;
    end
    if (mem_re) begin
      rdata <= mem[read_index[ADDR_W-1:0]];
    end
  end

  assign res_valid           = r_valid;
  assign res_item.event_res  = r_event;
  assign res_item.frame_type = r_type;
  assign res_item.frame_size = r_size;
  assign res_item.read_data  = r_use_mem ? rdata : '0;

endmodule

// File: hdl/checksummed_frame_receiver.sv
`timescale 1ns / 1ps
// Checksummed frame receiver: hunts for the start marker, collects the size,
// type and 16-bit checksum (low byte first) header, stores the payload and
// checks its wrapping 16-bit sum. One stream transaction can be taken every
// cycle unless the result register is held by output back-pressure; the op
// code sits in s_axis_tuser. A result leaves through a result register and
// a two-entry output buffer; the registered payload memory read lines up
// with the result register. While a good frame is held, received bytes are
// answered as refused. The payload memory is not cleared after reset.
module checksummed_frame_receiver #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte, read_index
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // frame_type, frame_size, read_data
  output logic [2:0]  m_axis_tuser,  // event_res
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata      // start_marker
);
  import cfr_pkg::*;

  logic      res_valid;
  logic      res_ready;
  cfr_item_t res_item;
  cfr_item_t out_item;

  assign cfg_tready = 1'b1;

  cfr_core #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .rx_byte    (s_axis_tdata[7:0]),
    .read_index (s_axis_tdata[15:8]),
    .cfg_valid  (cfg_tvalid),
    .cfg_data   (cfg_tdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  cfr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_item   (res_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tuser = out_item.event_res;
  assign m_axis_tdata = {out_item.read_data, out_item.frame_size, out_item.frame_type};

endmodule

// File: bench/checksummed_frame_receiver_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the checksummed frame receiver
module checksummed_frame_receiver_tb;
  import cfr_pkg::*;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;

  class deframer_scoreboard;
    localparam int unsigned MAX_REPORTS = 10;

    logic [7:0]  marker;
    bit          hunting;
    bit          ready;
    logic [8:0]  count;
    logic [7:0]  len;
    logic [7:0]  ftype;
    logic [15:0] check_word;
    logic [15:0] payload_sum;
    logic [7:0]  payload [0:255];
    cfr_item_t   expected_results [$];
    int unsigned mismatches;

    function new();
      marker      = START_MARKER_RESET;
      hunting     = 1'b1;
      ready       = 1'b0;
      count       = '0;
      len         = '0;
      ftype       = '0;
      check_word  = '0;
      payload_sum = '0;
      mismatches  = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void add_expected(cfr_event_t ev, logic [7:0] ty, logic [7:0] sz,
                               logic [7:0] dt);
      cfr_item_t want;
      want.event_res  = ev;
      want.frame_type = ty;
      want.frame_size = sz;
      want.read_data  = dt;
      expected_results.push_back(want);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [8:0] pos;
      if (ready) begin
        add_expected(EV_BUSY, ftype, len, 8'h00);
        return;
      end
      if (hunting) begin
        if (b == marker) begin
          hunting     = 1'b0;
          count       = 9'd1;
          payload_sum = '0;
          add_expected(EV_TAKEN, 8'h00, 8'h00, 8'h00);
        end
        return;
      end
      case (count)
        CNT_LEN:   len = b;
        CNT_TYPE:  ftype = b;
        CNT_CK_LO: check_word[7:0] = b;
        CNT_CK_HI: check_word[15:8] = b;
        default: begin
          pos = count - HDR_BYTES;
          if (pos < 9'd256) payload[pos[7:0]] = b;
          payload_sum = payload_sum + 16'(b);
        end
      endcase
      count = count + 9'd1;
      if (count >= 9'd3 && count >= {1'b0, len} + HDR_BYTES) begin
        if (payload_sum == check_word) begin
          ready = 1'b1;
          add_expected(EV_GOOD, ftype, len, 8'h00);
        end else begin
          hunting = 1'b1;
          count   = '0;
          add_expected(EV_BAD, ftype, len, 8'h00);
        end
      end else begin
        add_expected(EV_TAKEN, 8'h00, 8'h00, 8'h00);
      end
    endfunction

    function void predict_transaction(logic [1:0] op, logic [7:0] rx, logic [7:0] idx);
      logic [7:0] dt;
      dt = 8'h00;
      case (op)
        OP_BYTE: take_byte(rx);
        OP_READ: begin
          if (!ready) begin
            add_expected(EV_NOFRAME, 8'h00, 8'h00, 8'h00);
          end else begin
            if (idx < len) dt = payload[idx];
            add_expected(EV_READ, ftype, len, dt);
          end
        end
        OP_RELEASE: begin
          if (!ready) begin
            add_expected(EV_NOFRAME, 8'h00, 8'h00, 8'h00);
          end else begin
            ready   = 1'b0;
            hunting = 1'b1;
            count   = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(cfr_item_t got);
      cfr_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: event %0d type %02h size %02h data %02h",
                   got.event_res, got.frame_type, got.frame_size, got.read_data);
        return;
      end
      want = expected_results.pop_front();
      if (got.event_res !== want.event_res || got.frame_type !== want.frame_type ||
          got.frame_size !== want.frame_size || got.read_data !== want.read_data) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected event %0d type %02h size %02h data %02h, got %0d %02h %02h %02h",
                   want.event_res, want.frame_type, want.frame_size, want.read_data,
                   got.event_res, got.frame_type, got.frame_size, got.read_data);
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // rx_byte, read_index
  logic [1:0]  s_axis_tuser  = '0;  // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // frame_type, frame_size, read_data
  logic [2:0]  m_axis_tuser;        // event_res
  logic        cfg_tvalid    = 1'b0;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata     = '0;  // start_marker

  deframer_scoreboard sb = new();
  int unsigned items_sent = 0;
  bit          no_idling  = 1'b0;
  bit          hold_req   = 1'b0;

  checksummed_frame_receiver u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_tvalid    (cfg_tvalid),
    .cfg_tready    (cfg_tready),
    .cfg_tdata     (cfg_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(logic [1:0] op, logic [7:0] rx, logic [7:0] idx);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, rx};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_transaction(op, rx, idx);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(logic [7:0] value);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    sb.marker = value;
  endtask

  function automatic int unsigned pick_size();
    if ($urandom_range(0, 39) == 0) return $urandom_range(16, 64);
    return $urandom_range(0, 10);
  endfunction

  task automatic send_frame(int unsigned size, bit corrupt, bit truncate);
    logic [7:0]  body [$];
    logic [7:0]  frame_bytes [$];
    logic [15:0] check;
    logic [7:0]  b;
    int unsigned cut;
    int unsigned i;
    // bring the block back to hunting first
    while (sb.ready || !sb.hunting) begin
      if (sb.ready) send_item(OP_RELEASE, 8'($urandom), 8'($urandom));
      else send_item(OP_BYTE, 8'($urandom_range(0, 15)), 8'($urandom));
    end
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == sb.marker) b = b ^ 8'h01;
      send_item(OP_BYTE, b, 8'($urandom));
    end
    check = '0;
    for (i = 0; i < size; i++) begin
      b = 8'($urandom);
      body.push_back(b);
      check = check + 16'(b);
    end
    if (corrupt) check = check ^ 16'($urandom_range(1, 65535));
    frame_bytes = {sb.marker, 8'(size), 8'($urandom), check[7:0], check[15:8]};
    frame_bytes = {frame_bytes, body};
    cut = truncate ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
    for (i = 0; i < cut; i++) begin
      if (i > 0 && $urandom_range(0, 15) == 0)
        send_item($urandom_range(0, 1) ? OP_READ : OP_RELEASE, 8'($urandom), 8'($urandom));
      send_item(OP_BYTE, frame_bytes[i], 8'($urandom));
    end
    if (sb.ready) begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 2))
          0: begin
            if (size > 0) send_item(OP_READ, 8'($urandom), 8'($urandom_range(0, size - 1)));
            else send_item(OP_READ, 8'($urandom), 8'($urandom));
          end
          1: send_item(OP_READ, 8'($urandom), 8'($urandom));
          default: send_item(OP_BYTE, 8'($urandom), 8'($urandom));
        endcase
      end
      if ($urandom_range(0, 7) != 0) send_item(OP_RELEASE, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_until(int unsigned target);
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: send_item(2'($urandom), 8'($urandom), 8'($urandom));
        1: send_frame(pick_size(), 1'b0, 1'b1);
        2: send_frame(pick_size(), 1'b1, 1'b0);
        default: send_frame(pick_size(), 1'b0, 1'b0);
      endcase
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(cfr_item_t'({m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                                     m_axis_tdata[23:16]}));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_tvalid && cfg_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** checksummed_frame_receiver: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no frame held yet
    send_item(OP_READ, 8'h00, 8'h00);
    send_item(OP_RELEASE, 8'h00, 8'h00);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_item(OP_BYTE, 8'h00, 8'h00);
    // empty frame, checked on the checksum high byte
    send_item(OP_BYTE, START_MARKER_RESET, 8'h00);
    send_item(OP_BYTE, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'hFF, 8'h00);
    send_item(OP_BYTE, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'h00, 8'h00);
    // refused byte and out of range read while held
    send_item(OP_BYTE, 8'h55, 8'h00);
    send_item(OP_READ, 8'h00, 8'h00);
    send_item(OP_RELEASE, 8'h00, 8'h00);
    // two byte frame with a release in the middle of collection
    send_item(OP_BYTE, START_MARKER_RESET, 8'h00);
    send_item(OP_BYTE, 8'h02, 8'h00);
    send_item(OP_BYTE, 8'hA5, 8'h00);
    send_item(OP_RELEASE, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'hFE, 8'h00);
    send_item(OP_BYTE, 8'h01, 8'h00);
    send_item(OP_BYTE, 8'hFF, 8'h00);
    send_item(OP_BYTE, 8'hFF, 8'h00);
    send_item(OP_READ, 8'h00, 8'h01);
    send_item(OP_READ, 8'h00, 8'hFF);
    send_item(OP_RELEASE, 8'h00, 8'h00);

    random_until(200);
    wait_drained();
    write_marker(8'h00);
    hold_req = 1'b1;
    random_until(350);
    wait_drained();
    write_marker(8'hFF);
    send_frame(255, 1'b0, 1'b0);
    random_until(650);
    wait_drained();
    write_marker(8'($urandom_range(1, 254)));
    no_idling = 1'b1;
    random_until(750);
    wait_drained();

    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("** checksummed_frame_receiver: PASSED **");
    else
      $display("** checksummed_frame_receiver: FAILED **");
    $finish;
  end

endmodule
